>>> hdl/iwae_pkg.sv
// shared types and constants for the indexed word array engine
`timescale 1ns / 1ps
package iwae_pkg;

	localparam int CAP    = 64;
	localparam int ADDR_W = $clog2(CAP);
	localparam int LEN_W  = $clog2(CAP + 1);

	typedef enum logic [3:0] {
		ACT_APPEND   = 4'd0,
		ACT_ADD      = 4'd1,
		ACT_SET      = 4'd2,
		ACT_INSERT   = 4'd3,
		ACT_REMOVE   = 4'd4,
		ACT_REMALL   = 4'd5,
		ACT_TRUNCATE = 4'd6,
		ACT_NTH      = 4'd7,
		ACT_MAX      = 4'd8,
		ACT_FIND     = 4'd9,
		ACT_BSEARCH  = 4'd10,
		ACT_UNIQ     = 4'd11,
		ACT_SIZE     = 4'd12,
		ACT_CLEAR    = 4'd13
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_FILL,
		S_RD,
		S_EV,
		S_BSRD,
		S_BSEV,
		S_WRV,
		S_FIN
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DISP,
		CMD_FILL,
		CMD_READ,
		CMD_EVAL,
		CMD_BSEVAL,
		CMD_WRITE,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		cmd_t op;
	} dp_cmd_t;

	typedef struct packed {
		action_t act;
		logic    bad;
		logic    fill_need;
		logic    shift;
		logic    loop_empty;
		logic    last;
		logic    post_write;
		logic    slot_free;
	} dp_stat_t;

endpackage

>>> hdl/iwae_ctrl.sv
// controller state machine sequencing each action
`timescale 1ns / 1ps
module iwae_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  iwae_pkg::dp_stat_t stat,
	output iwae_pkg::dp_cmd_t  cmd
);
	import iwae_pkg::*;

	state_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (in_valid) st_d = S_DISP;
			end
			S_DISP: begin
				if (stat.bad) begin
					st_d = S_FIN;
				end else begin
					case (stat.act)
						ACT_APPEND: st_d = S_WRV;
						ACT_ADD: st_d = stat.loop_empty ? S_WRV : S_RD;
						ACT_SET: st_d = stat.fill_need ? S_FILL : S_WRV;
						ACT_INSERT: begin
							if (stat.fill_need) st_d = S_FILL;
							else if (stat.shift) st_d = S_RD;
							else st_d = S_WRV;
						end
						ACT_TRUNCATE: st_d = stat.fill_need ? S_FILL : S_FIN;
						ACT_REMOVE, ACT_NTH, ACT_REMALL, ACT_MAX, ACT_FIND, ACT_UNIQ:
							st_d = stat.loop_empty ? S_FIN : S_RD;
						ACT_BSEARCH: st_d = stat.loop_empty ? S_FIN : S_BSRD;
						default: st_d = S_FIN;
					endcase
				end
			end
			S_FILL: begin
				if (stat.last) st_d = (stat.act == ACT_TRUNCATE) ? S_FIN : S_WRV;
			end
			S_RD: st_d = S_EV;
			S_EV: begin
				if (stat.last) st_d = stat.post_write ? S_WRV : S_FIN;
				else st_d = S_RD;
			end
			S_BSRD: st_d = S_BSEV;
			S_BSEV: st_d = stat.last ? S_FIN : S_BSRD;
			S_WRV: st_d = S_FIN;
			S_FIN: begin
				if (stat.slot_free) st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = CMD_NONE;
		unique case (st_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = CMD_LOAD;
			end
			S_DISP: cmd.op = CMD_DISP;
			S_FILL: cmd.op = CMD_FILL;
			S_RD:   cmd.op = CMD_READ;
			S_EV:   cmd.op = CMD_EVAL;
			S_BSRD: cmd.op = CMD_READ;
			S_BSEV: cmd.op = CMD_BSEVAL;
			S_WRV:  cmd.op = CMD_WRITE;
			S_FIN: begin
				if (stat.slot_free) cmd.op = CMD_FINISH;
			end
			default: cmd.op = CMD_NONE;
		endcase
	end

	a_load_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE && in_valid) |=> (st_q == S_DISP))
		else $error("accepted beat not dispatched");
	a_rd_ev: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_RD) |=> (st_q == S_EV))
		else $error("read not followed by evaluate");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (st_q == S_IDLE))
		else $error("ready outside idle");

endmodule

>>> hdl/iwae_dp.sv
// datapath: word store, cursors, result and output registers
`timescale 1ns / 1ps
module iwae_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  iwae_pkg::dp_cmd_t  cmd,
	output iwae_pkg::dp_stat_t stat,
	input  logic [3:0]         action,
	input  logic signed [6:0]  index,
	input  logic [63:0]        value,
	input  logic [6:0]         new_length,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        word_out,
	output logic signed [6:0]  position,
	output logic [6:0]         length_out,
	output logic [1:0]         status
);
	import iwae_pkg::*;

	logic [63:0] mem [CAP];
	logic [63:0] rdata_q;

	action_t          act_q;
	logic [6:0]       idx_q;
	logic [63:0]      val_q;
	logic [6:0]       nl_q;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] k_q, k_d, w_q, w_d;
	logic signed [7:0] r_q, r_d, r_c;
	logic signed [7:0] lo_q, lo_d, hi_q, hi_d;
	logic [63:0]      acc_q, acc_d;
	logic [63:0]      res_word_q, res_word_d;
	logic [6:0]       res_pos_q, res_pos_d;
	status_t          res_st_q, res_st_d;
	logic             ov_q;

	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [63:0]       wdata;
	logic [LEN_W-1:0]  k_nx, w_nx, ft, r_len;
	logic [7:0]        mid_sum;
	logic [LEN_W-1:0]  mid;
	logic              keep, r_neg, r_ge_len, r_ge_cap, full;
	logic [7:0]        r_u;

	assign r_c      = idx_q[6] ? ($signed({idx_q[6], idx_q}) + $signed({1'b0, len_q}))
	                           : $signed({1'b0, idx_q});
	assign r_u      = r_c;
	assign r_neg    = r_c[7];
	assign r_ge_len = !r_neg && (r_u[6:0] >= len_q);
	assign r_ge_cap = !r_neg && (r_u >= 8'(CAP));
	assign full     = (len_q >= LEN_W'(CAP));
	assign r_len    = r_q[LEN_W-1:0];
	assign k_nx     = k_q + 1'b1;
	assign ft       = (act_q == ACT_TRUNCATE) ? nl_q : r_len;
	assign mid_sum  = lo_q + hi_q;
	assign mid      = mid_sum[LEN_W:1];

	always_comb begin
		len_d      = len_q;
		k_d        = k_q;
		w_d        = w_q;
		r_d        = r_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		acc_d      = acc_q;
		res_word_d = res_word_q;
		res_pos_d  = res_pos_q;
		res_st_d   = res_st_q;
		we         = 1'b0;
		waddr      = k_q[ADDR_W-1:0];
		wdata      = '0;
		re         = 1'b0;
		raddr      = k_q[ADDR_W-1:0];
		keep       = 1'b0;
		w_nx       = w_q;
		stat.act        = act_q;
		stat.bad        = 1'b0;
		stat.fill_need  = 1'b0;
		stat.shift      = 1'b0;
		stat.loop_empty = (len_q == '0);
		stat.last       = 1'b0;
		stat.post_write = 1'b0;
		stat.slot_free  = !ov_q || out_ready;

		case (act_q)
			ACT_SET: begin
				stat.bad       = r_neg || r_ge_cap;
				stat.fill_need = !r_neg && (r_u[6:0] > len_q);
			end
			ACT_INSERT: begin
				stat.bad       = r_neg || (r_ge_len ? r_ge_cap : full);
				stat.fill_need = !r_neg && (r_u[6:0] > len_q);
				stat.shift     = !r_ge_len;
			end
			ACT_REMOVE, ACT_NTH, ACT_FIND: stat.bad = r_neg || r_ge_len;
			ACT_TRUNCATE: begin
				stat.bad       = (nl_q > 7'(CAP));
				stat.fill_need = (nl_q > len_q);
			end
			default: ;
		endcase

		case (cmd.op)
			CMD_DISP: begin
				r_d        = r_c;
				res_word_d = '0;
				res_pos_d  = '1;
				res_st_d   = ST_OK;
				acc_d      = '0;
				k_d        = '0;
				w_d        = '0;
				lo_d       = '0;
				hi_d       = $signed({1'b0, len_q}) - 8'sd1;
				case (act_q)
					ACT_SET, ACT_INSERT: begin
						if (r_neg) res_st_d = ST_BAD;
						else if (stat.bad) res_st_d = ST_FULL;
						if (stat.fill_need) k_d = len_q;
						else k_d = len_q - 1'b1;
					end
					ACT_REMOVE, ACT_NTH, ACT_FIND: begin
						if (stat.bad) res_st_d = ST_BAD;
						k_d = r_u[LEN_W-1:0];
						w_d = r_u[LEN_W-1:0];
					end
					ACT_TRUNCATE: begin
						if (stat.bad) begin
							res_st_d = ST_FULL;
						end else begin
							len_d = nl_q;
							k_d   = len_q;
						end
					end
					ACT_CLEAR: len_d = '0;
					default: ;
				endcase
			end
			CMD_FILL: begin
				we        = 1'b1;
				waddr     = k_q[ADDR_W-1:0];
				wdata     = '0;
				k_d       = k_nx;
				stat.last = (k_nx == ft);
			end
			CMD_READ: begin
				re    = 1'b1;
				raddr = (act_q == ACT_BSEARCH) ? mid[ADDR_W-1:0] : k_q[ADDR_W-1:0];
			end
			CMD_EVAL: begin
				k_d       = k_nx;
				stat.last = (k_nx == len_q);
				case (act_q)
					ACT_ADD, ACT_FIND: begin
						if (rdata_q == val_q) begin
							res_pos_d = k_q;
							stat.last = 1'b1;
						end else begin
							stat.post_write = (act_q == ACT_ADD);
						end
					end
					ACT_INSERT: begin
						we              = 1'b1;
						waddr           = k_nx[ADDR_W-1:0];
						wdata           = rdata_q;
						k_d             = k_q - 1'b1;
						stat.last       = (k_q == r_len);
						stat.post_write = 1'b1;
					end
					ACT_NTH: begin
						res_word_d = rdata_q;
						res_pos_d  = r_len;
						stat.last  = 1'b1;
					end
					ACT_MAX: begin
						if (rdata_q > res_word_q) res_word_d = rdata_q;
					end
					ACT_REMOVE, ACT_REMALL, ACT_UNIQ: begin
						case (act_q)
							ACT_REMOVE: keep = (k_q != r_len);
							ACT_REMALL: keep = (rdata_q != val_q);
							default:    keep = (k_q == '0) || (rdata_q != acc_q);
						endcase
						if (act_q == ACT_REMOVE && !keep) begin
							res_word_d = rdata_q;
							res_pos_d  = r_len;
						end
						acc_d = rdata_q;
						if (keep) begin
							we    = 1'b1;
							waddr = w_q[ADDR_W-1:0];
							wdata = rdata_q;
						end
						w_nx = keep ? (w_q + 1'b1) : w_q;
						w_d  = w_nx;
						if (stat.last) begin
							len_d = w_nx;
							if (act_q == ACT_REMALL) res_word_d = 64'(len_q - w_nx);
						end
					end
					default: stat.last = 1'b1;
				endcase
			end
			CMD_BSEVAL: begin
				if (rdata_q == val_q) begin
					res_pos_d = mid;
					stat.last = 1'b1;
				end else if (rdata_q > val_q) begin
					hi_d      = $signed({1'b0, mid}) - 8'sd1;
					stat.last = (mid == '0) || (lo_q > hi_d);
				end else begin
					lo_d      = $signed({1'b0, mid}) + 8'sd1;
					stat.last = (lo_d > hi_q);
				end
			end
			CMD_WRITE: begin
				wdata = val_q;
				case (act_q)
					ACT_APPEND, ACT_ADD: begin
						if (full) begin
							res_st_d = ST_FULL;
						end else begin
							we        = 1'b1;
							waddr     = len_q[ADDR_W-1:0];
							res_pos_d = len_q;
							len_d     = len_q + 1'b1;
						end
					end
					default: begin
						we        = 1'b1;
						waddr     = r_len[ADDR_W-1:0];
						res_pos_d = r_len;
						if (r_len >= len_q) len_d = r_len + 1'b1;
						else if (act_q == ACT_INSERT) len_d = len_q + 1'b1;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			len_q <= len_d;
			if (cmd.op == CMD_FINISH) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_LOAD) begin
			act_q <= action_t'(action);
			idx_q <= index;
			val_q <= value;
			nl_q  <= new_length;
		end
		k_q        <= k_d;
		w_q        <= w_d;
		r_q        <= r_d;
		lo_q       <= lo_d;
		hi_q       <= hi_d;
		acc_q      <= acc_d;
		res_word_q <= res_word_d;
		res_pos_q  <= res_pos_d;
		res_st_q   <= res_st_d;
		if (cmd.op == CMD_FINISH) begin
			word_out   <= res_word_q;
			position   <= res_pos_q;
			length_out <= len_q;
			status     <= res_st_q;
		end
	end

	assign out_valid = ov_q;

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAP))
		else $error("length past capacity");
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_EVAL && (act_q == ACT_REMALL || act_q == ACT_UNIQ)) |-> (w_q <= k_q))
		else $error("compaction write cursor ahead of read cursor");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_FINISH) |=> ov_q)
		else $error("finished result not presented");

endmodule

>>> hdl/indexed_word_array_engine_top.sv
// top level of the indexed word array engine
`timescale 1ns / 1ps
// channel  handshake             fields
// in       in_valid / in_ready   action index value new_length
// out      out_valid / out_ready word_out position length_out status
// one beat at a time; each beat is dispatched, then walks the words it needs
// shifts, scans, compaction and zero fill walk the single-port store one word a step
// bsearch reads then evaluates each probe; a result waits in the output register
// while the next in beat is taken; reset clears length and the output valid
module indexed_word_array_engine_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [3:0]        action,
	input  logic signed [6:0] index,
	input  logic [63:0]       value,
	input  logic [6:0]        new_length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       word_out,
	output logic signed [6:0] position,
	output logic [6:0]        length_out,
	output logic [1:0]        status
);
	import iwae_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	iwae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	iwae_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.action     (action),
		.index      (index),
		.value      (value),
		.new_length (new_length),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_out   (word_out),
		.position   (position),
		.length_out (length_out),
		.status     (status)
	);

endmodule

>>> sim/array_result_checker.sv
// checker that predicts and compares every result beat of the word array engine
`timescale 1ns / 1ps
module array_result_checker
	import iwae_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [3:0]        action,
	input  logic signed [6:0] index,
	input  logic [63:0]       value,
	input  logic [6:0]        new_length,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [63:0]       word_out,
	input  logic signed [6:0] position,
	input  logic [6:0]        length_out,
	input  logic [1:0]        status,
	output int                fail_count,
	output int                pending
);

	typedef struct {
		logic [63:0] word;
		logic [6:0]  pos;
		logic [6:0]  len;
		logic [1:0]  st;
	} array_result_t;

	logic [63:0]   words [CAP];
	int            count;
	array_result_t awaited [$];

	function automatic int resolve_index(int idx);
		if (idx < 0) begin
			idx += count;
			if (idx < 0)
				return -1;
		end
		return idx;
	endfunction

	function automatic int scan_words(int start, logic [63:0] v);
		for (int k = start; k < count; k++)
			if (words[k] == v)
				return k;
		return -1;
	endfunction

	function automatic logic [63:0] pull_word(int i);
		logic [63:0] w;
		w = words[i];
		for (int k = i; k + 1 < count; k++)
			words[k] = words[k + 1];
		count--;
		words[count] = '0;
		return w;
	endfunction

	function automatic array_result_t apply_action(logic [3:0] act, logic signed [6:0] ix,
			logic [63:0] v, logic [6:0] nl);
		array_result_t res;
		int r, p, lo, hi, mid, k;
		logic [63:0] w;
		logic [1:0] st;
		w = '0;
		p = -1;
		st = ST_OK;
		case (act)
			ACT_APPEND, ACT_ADD: begin
				if (act == ACT_ADD)
					p = scan_words(0, v);
				if (p < 0) begin
					if (count >= CAP) begin
						st = ST_FULL;
					end else begin
						words[count] = v;
						p = count;
						count++;
					end
				end
			end
			ACT_SET: begin
				r = resolve_index(int'(ix));
				if (r < 0) begin
					st = ST_BAD;
				end else if (r >= CAP) begin
					st = ST_FULL;
				end else begin
					words[r] = v;
					if (r >= count)
						count = r + 1;
					p = r;
				end
			end
			ACT_INSERT: begin
				r = resolve_index(int'(ix));
				if (r < 0) begin
					st = ST_BAD;
				end else if (r >= count) begin
					if (r >= CAP) begin
						st = ST_FULL;
					end else begin
						words[r] = v;
						count = r + 1;
						p = r;
					end
				end else if (count >= CAP) begin
					st = ST_FULL;
				end else begin
					for (k = count; k > r; k--)
						words[k] = words[k - 1];
					words[r] = v;
					count++;
					p = r;
				end
			end
			ACT_REMOVE, ACT_NTH: begin
				r = resolve_index(int'(ix));
				if (r < 0 || r >= count) begin
					st = ST_BAD;
				end else begin
					w = (act == ACT_REMOVE) ? pull_word(r) : words[r];
					p = r;
				end
			end
			ACT_REMALL: begin
				r = scan_words(0, v);
				while (r >= 0) begin
					void'(pull_word(r));
					w++;
					r = scan_words(r, v);
				end
			end
			ACT_TRUNCATE: begin
				if (int'(nl) > CAP) begin
					st = ST_FULL;
				end else begin
					for (k = int'(nl); k < count; k++)
						words[k] = '0;
					count = int'(nl);
				end
			end
			ACT_MAX: begin
				for (k = 0; k < count; k++)
					if (words[k] > w)
						w = words[k];
			end
			ACT_FIND: begin
				r = resolve_index(int'(ix));
				if (r < 0 || r >= count)
					st = ST_BAD;
				else
					p = scan_words(r, v);
			end
			ACT_BSEARCH: begin
				lo = 0;
				hi = count - 1;
				while (lo <= hi) begin
					mid = lo + (hi - lo) / 2;
					if (words[mid] == v) begin
						p = mid;
						break;
					end
					if (words[mid] > v) begin
						if (mid == 0)
							break;
						hi = mid - 1;
					end else begin
						lo = mid + 1;
					end
				end
			end
			ACT_UNIQ: begin
				k = 1;
				while (k < count) begin
					if (words[k - 1] == words[k])
						void'(pull_word(k));
					else
						k++;
				end
			end
			ACT_CLEAR: begin
				for (k = 0; k < CAP; k++)
					words[k] = '0;
				count = 0;
			end
			default: ;
		endcase
		res.word = w;
		res.pos = p[6:0];
		res.len = count[6:0];
		res.st = st;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		array_result_t exp_res;
		if (!arst_n) begin
			for (int k = 0; k < CAP; k++)
				words[k] = '0;
			count = 0;
			fail_count <= 0;
			pending <= 0;
			awaited.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					$error("result beat with nothing awaited");
					fail_count <= fail_count + 1;
				end else begin
					exp_res = awaited.pop_front();
					if (word_out !== exp_res.word || position !== exp_res.pos ||
						length_out !== exp_res.len || status !== exp_res.st)
						fail_count <= fail_count + 1;
					if (word_out !== exp_res.word)
						$error("word_out expected %h actual %h", exp_res.word, word_out);
					if (position !== exp_res.pos)
						$error("position expected %0d actual %0d",
							$signed(exp_res.pos), position);
					if (length_out !== exp_res.len)
						$error("length_out expected %0d actual %0d", exp_res.len, length_out);
					if (status !== exp_res.st)
						$error("status expected %0d actual %0d", exp_res.st, status);
				end
			end
			if (in_valid && in_ready)
				awaited.push_back(apply_action(action, index, value, new_length));
			pending <= awaited.size();
		end
	end

endmodule

>>> sim/testbench.sv
// stimulus and verdict for the indexed word array engine
`timescale 1ns / 1ps
module testbench;
	import iwae_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [3:0]        action;
	logic signed [6:0] index;
	logic [63:0]       value;
	logic [6:0]        new_length;
	logic              out_valid;
	logic              out_ready;
	logic [63:0]       word_out;
	logic signed [6:0] position;
	logic [6:0]        length_out;
	logic [1:0]        status;
	int                fail_count;
	int                pending;
	logic              hold_off;

	indexed_word_array_engine_top dut (.*);

	array_result_checker checker_i (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// small value pool so that matches, duplicates and sorted runs happen
	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom};
			1: return 64'(($urandom_range(0, 1)) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0);
			default: return 64'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic send_beat(logic [3:0] act, logic signed [6:0] ix, logic [63:0] v,
			logic [6:0] nl);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		index <= ix;
		value <= v;
		new_length <= nl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic random_beat();
		logic [3:0] act;
		logic signed [6:0] ix;
		int w;
		w = $urandom_range(0, 99);
		if (w < 30)
			act = ($urandom_range(0, 1)) ? ACT_APPEND : ACT_ADD;
		else if (w < 96)
			act = 4'($urandom_range(2, 12));
		else if (w < 98)
			act = ACT_CLEAR;
		else
			act = 4'($urandom_range(14, 15));
		ix = 7'($urandom_range(0, 127));
		if ($urandom_range(0, 1))
			ix = 7'($urandom_range(0, 20));
		send_beat(act, ix, pick_value(), 7'($urandom_range(0, 127)));
	endtask

	initial begin
		in_valid = 1'b0;
		action = ACT_SIZE;
		index = '0;
		value = '0;
		new_length = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// empty array reads, find and bsearch, then directed edge cases for the other actions
		send_beat(ACT_FIND, 7'sd0, 64'd1, 7'd0);
		send_beat(ACT_NTH, -7'sd1, 64'd0, 7'd0);
		send_beat(ACT_BSEARCH, 7'sd0, 64'd0, 7'd0);
		send_beat(ACT_MAX, 7'sd0, 64'd0, 7'd0);
		send_beat(ACT_APPEND, 7'sd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
		send_beat(ACT_ADD, 7'sd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
		send_beat(ACT_SET, 7'sd5, 64'd3, 7'd0);
		send_beat(ACT_INSERT, 7'sd10, 64'd9, 7'd0);
		send_beat(ACT_INSERT, -7'sd64, 64'd9, 7'd0);
		send_beat(ACT_INSERT, 7'sd1, 64'd0, 7'd0);
		send_beat(ACT_FIND, -7'sd3, 64'd9, 7'd0);
		send_beat(ACT_BSEARCH, 7'sd0, 64'd0, 7'd0);
		send_beat(ACT_UNIQ, 7'sd0, 64'd0, 7'd0);
		send_beat(ACT_REMALL, 7'sd0, 64'd9, 7'd0);
		send_beat(ACT_REMOVE, -7'sd1, 64'd0, 7'd0);
		send_beat(ACT_SET, 7'sd63, 64'd1, 7'd0);
		send_beat(ACT_APPEND, 7'sd0, 64'd1, 7'd0);
		send_beat(ACT_INSERT, 7'sd0, 64'd1, 7'd0);
		send_beat(ACT_TRUNCATE, 7'sd0, 64'd0, 7'd127);
		send_beat(ACT_TRUNCATE, 7'sd0, 64'd0, 7'd64);
		send_beat(ACT_TRUNCATE, 7'sd0, 64'd0, 7'd3);
		send_beat(ACT_SIZE, 7'sd0, 64'd0, 7'd0);
		send_beat(4'd15, 7'sd0, 64'd0, 7'd0);
		send_beat(ACT_CLEAR, 7'sd0, 64'd0, 7'd0);
		for (int n = 0; n < 750; n++)
			random_beat();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// long receiver hold-off once, otherwise random stalls per beat
	initial begin
		hold_off = 1'b0;
		wait (arst_n);
		repeat (2000) @(posedge clk);
		hold_off = 1'b1;
		repeat (600) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (stall > 0 || hold_off) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (hold_off)
					@(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

endmodule
